// ----- design/chist_pkg.sv -----
// ----------------------------------------------------------------------------
// chist_pkg
// Shared types, constants and helpers for the channel histogram block.
// ----------------------------------------------------------------------------
package chist_pkg;

   localparam int CountBits = 24;
   localparam int NumBins   = 256;
   localparam int BinBits   = $clog2(NumBins);
   localparam int PixBits   = 8;
   localparam int BarBits   = 10;
   localparam int ProdBits  = BarBits + CountBits;
   localparam int IterBits  = $clog2(ProdBits + 1);
   localparam int OutCountBits = 24;

   localparam int ReqDataBits  = 4 * PixBits;
   localparam int RspFieldBits = BinBits + OutCountBits + BarBits;
   localparam int RspDataBits  = ((RspFieldBits + 7) / 8) * 8;

   localparam logic [BarBits-1:0] BarHeightReset = BarBits'(100);

   typedef enum logic [1:0] {
      ACT_PIXEL = 2'd0,
      ACT_QUERY = 2'd1,
      ACT_CLEAR = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      CH_RED   = 2'd0,
      CH_GREEN = 2'd1,
      CH_BLUE  = 2'd2,
      CH_LUMA  = 2'd3
   } channel_type;

   typedef enum logic {
      REG_CHANNEL = 1'b0,
      REG_BAR     = 1'b1
   } csr_index_type;

   // Bin memory command from the sequencer.
   typedef struct packed {
      logic                 rd_en;
      logic [BinBits-1:0]   rd_addr;
      logic                 wr_en;
      logic [BinBits-1:0]   wr_addr;
      logic [CountBits-1:0] wr_data;
      logic                 clear;
   } store_req_type;

   // Pick the bin of a pixel for the selected channel.
   function automatic logic [BinBits-1:0] pick_bin(
      input logic [1:0]         chan,
      input logic [PixBits-1:0] r,
      input logic [PixBits-1:0] g,
      input logic [PixBits-1:0] b
   );
      logic [12:0] sum;
      logic [BinBits-1:0] bin;
      sum = 13'(r) * 13'd11 + 13'(g) * 13'd16 + 13'(b) * 13'd5;
      case (channel_type'(chan))
         CH_RED:   bin = BinBits'(r);
         CH_GREEN: bin = BinBits'(g);
         CH_BLUE:  bin = BinBits'(b);
         CH_LUMA:  bin = BinBits'(sum[12:5]);
         default:  bin = BinBits'(r);
      endcase
      return bin;
   endfunction

endpackage

// ----- design/chist_div.sv -----
// ----------------------------------------------------------------------------
// chist_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module chist_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [chist_pkg::ProdBits-1:0]  dividend,
   input  logic [chist_pkg::CountBits-1:0] divisor,
   output logic                            done,
   output logic [chist_pkg::ProdBits-1:0]  quotient
);

   localparam int CB = chist_pkg::CountBits;
   localparam int PB = chist_pkg::ProdBits;
   localparam int IB = chist_pkg::IterBits;

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [IB-1:0] cnt_ff, cnt_in;
   logic [CB-1:0] rem_ff, rem_in;
   logic [PB-1:0] quo_ff, quo_in;
   logic [CB-1:0] dsr_ff, dsr_in;

   logic [CB:0]   shifted;
   logic [CB+1:0] diff;
   logic          borrow;

   assign shifted = {rem_ff, quo_ff[PB-1]};
   assign diff    = {1'b0, shifted} - {2'b00, dsr_ff};
   assign borrow  = diff[CB+1];

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         // Shift in one dividend bit, subtract when it fits.
         rem_in = borrow ? shifted[CB-1:0] : diff[CB-1:0];
         quo_in = {quo_ff[PB-2:0], ~borrow};
         cnt_in = cnt_ff + IB'(1);
         if (cnt_ff == IB'(PB - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ----- design/chist_store.sv -----
// ----------------------------------------------------------------------------
// chist_store
// Bin count memory with per-bin valid bits; an invalid bin reads as zero.
// ----------------------------------------------------------------------------
module chist_store (
   input  logic                            clock,
   input  logic                            reset,
   input  chist_pkg::store_req_type        req,
   output logic [chist_pkg::CountBits-1:0] rd_count
);

   localparam int CB = chist_pkg::CountBits;
   localparam int NB = chist_pkg::NumBins;

   logic [CB-1:0] bins_ff [NB];
   logic [NB-1:0] valid_ff;
   logic [CB-1:0] rd_data_ff;
   logic          rd_valid_ff;

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         bins_ff[req.wr_addr] <= req.wr_data;
      end
      if (req.rd_en) begin
         rd_data_ff <= bins_ff[req.rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || req.clear) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (req.wr_en) begin
            valid_ff[req.wr_addr] <= 1'b1;
         end
         if (req.rd_en) begin
            rd_valid_ff <= valid_ff[req.rd_addr];
         end
      end
   end

   assign rd_count = rd_valid_ff ? rd_data_ff : '0;

endmodule

// ----- design/channel_histogram_normalized.sv -----
// ----------------------------------------------------------------------------
// channel_histogram_normalized
// 256-bin histogram of one pixel channel with scaled bar-length queries.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one transaction per item: req_tuser holds the action
//   (count pixel, query bin, clear), req_tdata the pixel and the query bin.
//   rsp_* returns one transaction per query: bin index, count, bar length.
//   csr_* writes channel_select (index 0) or bar_height (index 1); write
//   only while the block is idle. csr_ready is always high.
// Sequence (one item at a time, req_tready high only in the idle state):
//   count pixel : accept, memory read, read-modify-write.
//   clear       : accept, then valid bits of all bins drop at once.
//   ignored code: accepted and dropped.
//   query       : accept, memory read, then the restoring divider
//                 computes floor(bar_height * count / peak).
// Reset: all bins read as zero, peak zero, channel red, bar_height 100.
// The response sits in an output register; a stalled receiver only holds
// the next query at its last step, pixels and clears still flow.
// ----------------------------------------------------------------------------
module channel_histogram_normalized (
   input  logic        clock,
   input  logic        reset,
   // Request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // red[7:0], green[15:8], blue[23:16], query_bin[31:24]
   input  logic [1:0]  req_tuser,   // action[1:0]
   // Response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // bin_index[7:0], bin_count[31:8], bar_length[41:32]
   // Register write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [9:0]  csr_data
);

   localparam int CB = chist_pkg::CountBits;
   localparam int BB = chist_pkg::BinBits;
   localparam int HB = chist_pkg::BarBits;
   localparam int PB = chist_pkg::ProdBits;
   localparam int PX = chist_pkg::PixBits;
   localparam int OB = chist_pkg::OutCountBits;
   localparam int RB = chist_pkg::RspDataBits;
   localparam int PadBits = RB - chist_pkg::RspFieldBits;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_EXEC,
      S_DIVGO,
      S_DIVW,
      S_OUT,
      S_CLEAR
   } state_type;

   state_type state_ff, state_in;

   // Configuration
   logic [1:0]    chan_ff, chan_in;
   logic [HB-1:0] bar_height_ff, bar_height_in;

   // Item context
   logic          is_query_ff, is_query_in;
   logic [BB-1:0] bin_ff, bin_in;
   logic [CB-1:0] peak_ff, peak_in;
   logic [CB-1:0] count_ff, count_in;
   logic [PB-1:0] prod_ff, prod_in;
   logic [HB-1:0] bar_ff, bar_in;

   // Response register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [RB-1:0] rsp_data_ff, rsp_data_in;

   chist_pkg::store_req_type store_req;
   logic [CB-1:0] rd_count;
   logic [CB-1:0] next_count;
   logic          div_start;
   logic          div_done;
   logic [PB-1:0] div_quo;
   logic          req_fire;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // Saturating increment of the bin just read.
   assign next_count = (rd_count == {CB{1'b1}}) ? rd_count : rd_count + CB'(1);

   chist_store u_store (
      .clock    (clock),
      .reset    (reset),
      .req      (store_req),
      .rd_count (rd_count)
   );

   chist_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_ff),
      .divisor  (peak_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_comb begin
      state_in      = state_ff;
      chan_in       = chan_ff;
      bar_height_in = bar_height_ff;
      is_query_in   = is_query_ff;
      bin_in        = bin_ff;
      peak_in       = peak_ff;
      count_in      = count_ff;
      prod_in       = prod_ff;
      bar_in        = bar_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      store_req     = '0;
      div_start     = 1'b0;

      // Register writes
      if (csr_valid) begin
         case (chist_pkg::csr_index_type'(csr_index))
            chist_pkg::REG_CHANNEL: chan_in       = csr_data[1:0];
            chist_pkg::REG_BAR:     bar_height_in = csr_data;
            default:                chan_in       = chan_ff;
         endcase
      end

      // Drop the response once the receiver takes it.
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               case (chist_pkg::action_type'(req_tuser))
                  chist_pkg::ACT_PIXEL: begin
                     bin_in      = chist_pkg::pick_bin(chan_ff, req_tdata[PX-1:0],
                                      req_tdata[2*PX-1:PX], req_tdata[3*PX-1:2*PX]);
                     is_query_in = 1'b0;
                     state_in    = S_READ;
                  end
                  chist_pkg::ACT_QUERY: begin
                     bin_in      = BB'(req_tdata[4*PX-1:3*PX]);
                     is_query_in = 1'b1;
                     state_in    = S_READ;
                  end
                  chist_pkg::ACT_CLEAR: begin
                     state_in = S_CLEAR;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_READ: begin
            store_req.rd_en   = 1'b1;
            store_req.rd_addr = bin_ff;
            state_in          = S_EXEC;
         end
         S_EXEC: begin
            if (is_query_ff) begin
               count_in = rd_count;
               prod_in  = PB'(bar_height_ff) * PB'(rd_count);
               if (peak_ff == '0) begin
                  bar_in   = '0;
                  state_in = S_OUT;
               end else begin
                  state_in = S_DIVGO;
               end
            end else begin
               // Write back the bumped count and track the peak.
               store_req.wr_en   = 1'b1;
               store_req.wr_addr = bin_ff;
               store_req.wr_data = next_count;
               if (next_count > peak_ff) begin
                  peak_in = next_count;
               end
               state_in = S_IDLE;
            end
         end
         S_DIVGO: begin
            div_start = 1'b1;
            state_in  = S_DIVW;
         end
         S_DIVW: begin
            if (div_done) begin
               bar_in   = div_quo[HB-1:0];
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            // Hold until the response register is free.
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {{PadBits{1'b0}}, bar_ff, OB'(count_ff), bin_ff};
               state_in     = S_IDLE;
            end
         end
         S_CLEAR: begin
            store_req.clear = 1'b1;
            peak_in         = '0;
            state_in        = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         chan_ff       <= 2'(chist_pkg::CH_RED);
         bar_height_ff <= chist_pkg::BarHeightReset;
         peak_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
         is_query_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         chan_ff       <= chan_in;
         bar_height_ff <= bar_height_in;
         peak_ff       <= peak_in;
         rsp_valid_ff  <= rsp_valid_in;
         is_query_ff   <= is_query_in;
      end
      bin_ff      <= bin_in;
      count_ff    <= count_in;
      prod_ff     <= prod_in;
      bar_ff      <= bar_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
